@@ design/prbs_pattern_bit_source_assert.svh @@
// Assertion macros used by the bit source module.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef PRBS_PATTERN_BIT_SOURCE_ASSERT_SVH
`define PRBS_PATTERN_BIT_SOURCE_ASSERT_SVH

// Same-cycle implication.
`define PBS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbs check failed");

// Next-cycle implication.
`define PBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbs check failed");

`endif

@@ design/pbs_pkg.sv @@
package pbs_pkg;

    // Shift register size and seed
    localparam int REG_BITS = 33;
    localparam logic [REG_BITS-1:0] PRBS_SEED = 33'h0_5555_554A;

    // Default pattern storage
    localparam int PATTERN_BITS_DEF = 64;

    // Configuration field widths
    localparam int MODE_W   = 2;
    localparam int LEN_W    = 6;
    localparam int LIMIT_W  = 32;
    localparam int SIZE_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRBS_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SIZE = 3'd4;

    // Source modes
    localparam logic [MODE_W-1:0] MODE_PRBS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CYCLIC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONESHOT = 2'd2;

    // Reset values of the registers
    localparam logic [LEN_W-1:0]   LEN_RESET   = 6'd31;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 7'd1;

    // Limits of the register length
    localparam logic [LEN_W-1:0] LEN_MIN = 6'd1;
    localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

    typedef logic [REG_BITS-1:0] prbs_state_t;

    function automatic prbs_state_t tb(input int k);
        tb = prbs_state_t'(1) << k;
    endfunction

    // Feedback tap set for each register length
    function automatic prbs_state_t tap_mask(input logic [LEN_W-1:0] len);
        case (len)
            6'd1:  tap_mask = tb(1);
            6'd2:  tap_mask = tb(2) | tb(1);
            6'd3:  tap_mask = tb(3) | tb(1);
            6'd4:  tap_mask = tb(4) | tb(1);
            6'd5:  tap_mask = tb(5) | tb(2);
            6'd6:  tap_mask = tb(6) | tb(1);
            6'd7:  tap_mask = tb(7) | tb(1);
            6'd8:  tap_mask = tb(8) | tb(4) | tb(3) | tb(2);
            6'd9:  tap_mask = tb(9) | tb(4);
            6'd10: tap_mask = tb(10) | tb(3);
            6'd11: tap_mask = tb(11) | tb(2);
            6'd12: tap_mask = tb(12) | tb(6) | tb(4) | tb(1);
            6'd13: tap_mask = tb(13) | tb(4) | tb(3) | tb(1);
            6'd14: tap_mask = tb(14) | tb(5) | tb(3) | tb(1);
            6'd15: tap_mask = tb(15) | tb(1);
            6'd16: tap_mask = tb(16) | tb(5) | tb(3) | tb(2);
            6'd17: tap_mask = tb(17) | tb(3);
            6'd18: tap_mask = tb(18) | tb(5) | tb(2) | tb(1);
            6'd19: tap_mask = tb(19) | tb(5) | tb(2) | tb(1);
            6'd20: tap_mask = tb(20) | tb(3);
            6'd21: tap_mask = tb(21) | tb(2);
            6'd22: tap_mask = tb(22) | tb(1);
            6'd23: tap_mask = tb(23) | tb(5);
            6'd24: tap_mask = tb(24) | tb(4) | tb(3) | tb(1);
            6'd25: tap_mask = tb(25) | tb(3);
            6'd26: tap_mask = tb(26) | tb(6) | tb(2) | tb(1);
            6'd27: tap_mask = tb(27) | tb(5) | tb(2) | tb(1);
            6'd28: tap_mask = tb(28) | tb(3);
            6'd29: tap_mask = tb(29) | tb(2);
            6'd30: tap_mask = tb(30) | tb(6) | tb(4) | tb(2);
            6'd31: tap_mask = tb(31) | tb(3);
            6'd32: tap_mask = tb(32) | tb(7) | tb(5) | tb(3) | tb(2) | tb(1);
            default: tap_mask = '0;
        endcase
    endfunction

endpackage

@@ design/pbs_lfsr.sv @@
module pbs_lfsr
    import pbs_pkg::*;
(
    input  prbs_state_t      state,
    input  logic [LEN_W-1:0] length,
    output prbs_state_t      state_next,
    output logic             out_bit
);

    logic [LEN_W-1:0] len_eff;
    prbs_state_t      shifted;

    // Clamp the length into the table range
    always_comb
    begin
        if (length < LEN_MIN)
            len_eff = LEN_MIN;
        else if (length > LEN_MAX)
            len_eff = LEN_MAX;
        else
            len_eff = length;
    end

    // Emit the element at the length
    assign out_bit = state[len_eff[5:0]];

    // Shift elements up to the length, hold the ones above
    always_comb
    begin
        shifted[0] = 1'b0;
        for (int i = 1; i < REG_BITS; i++)
        begin
            shifted[i] = (LEN_W'(i) <= len_eff) ? state[i-1] : state[i];
        end
    end

    // Feed back the parity of the tap set
    always_comb
    begin
        state_next    = shifted;
        state_next[0] = ^(shifted & tap_mask(len_eff));
    end

endmodule

@@ design/prbs_pattern_bit_source.sv @@
// Bit source: PRBS register of length 1 to 32, cyclic pattern or one-shot pattern.
// A request is answered in the cycle after acceptance, from the result register.
// Throughput: one request per cycle while a held result does not stall the input (in_stall).
// Requests that find no budget or an idle tick are taken and give no result.
// Reset (rst_n low, asynchronous): register seed 0x5555554A, pattern position 0,
// unlimited budget, mode PRBS, length 31, pattern 0 of size 1, no pending result.
module prbs_pattern_bit_source
    import pbs_pkg::*;
#(
    parameter int PATTERN_BITS = PATTERN_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    // request channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  slot_free,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  data_bit,
    output logic                  final_bit
);

`include "prbs_pattern_bit_source_assert.svh"

    localparam int POS_W = $clog2(PATTERN_BITS + 1);
    localparam int IDX_W = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;

    // Configuration registers
    logic [MODE_W-1:0]       source_mode_reg;
    logic [LEN_W-1:0]        prbs_length_reg;
    logic [PATTERN_BITS-1:0] pattern_word_reg;
    logic [SIZE_W-1:0]       pattern_size_reg;

    // Generator state
    prbs_state_t             shift_reg, shift_next;
    logic [POS_W-1:0]        pattern_pos_reg, pattern_pos_next;
    logic [LIMIT_W-1:0]      bits_left_reg, bits_left_next;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    logic                    data_bit_reg, data_bit_next;
    logic                    final_bit_reg, final_bit_next;

    logic                    out_free;
    logic                    in_acc;
    logic                    unlimited;
    logic                    gen;
    logic                    wr_limit;
    logic [SIZE_W-1:0]       size_eff;
    logic [POS_W-1:0]        rd_pos;
    logic                    prbs_bit;
    prbs_state_t             prbs_next;
    logic                    fin;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !out_free;
    assign in_acc    = in_valid && out_free;
    assign unlimited = bits_left_reg[LIMIT_W-1];
    assign gen       = in_acc && slot_free && (unlimited || (bits_left_reg != '0));
    assign wr_limit  = wr_en && (wr_index == CFG_BIT_LIMIT);

    // Register write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mode_reg  <= MODE_PRBS;
            prbs_length_reg  <= LEN_RESET;
            pattern_word_reg <= '0;
            pattern_size_reg <= SIZE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_SOURCE_MODE:  source_mode_reg  <= wr_data[MODE_W-1:0];
                CFG_PRBS_LENGTH:  prbs_length_reg  <= wr_data[LEN_W-1:0];
                CFG_PATTERN_WORD: pattern_word_reg <= wr_data[PATTERN_BITS-1:0];
                CFG_PATTERN_SIZE: pattern_size_reg <= wr_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    pbs_lfsr u_lfsr (
        .state      (shift_reg),
        .length     (prbs_length_reg),
        .state_next (prbs_next),
        .out_bit    (prbs_bit)
    );

    // Clamp the pattern size
    always_comb
    begin
        if (pattern_size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (pattern_size_reg > SIZE_W'(PATTERN_BITS))
            size_eff = SIZE_W'(PATTERN_BITS);
        else
            size_eff = pattern_size_reg;
    end

    // Produce the bit and advance the selected source
    always_comb
    begin
        shift_next       = shift_reg;
        pattern_pos_next = pattern_pos_reg;
        data_bit_next    = 1'b0;
        rd_pos           = pattern_pos_reg;
        case (source_mode_reg)
            MODE_PRBS:
            begin
                data_bit_next = prbs_bit;
                shift_next    = prbs_next;
            end
            MODE_CYCLIC:
            begin
                if (SIZE_W'(pattern_pos_reg) >= size_eff)
                    rd_pos = '0;
                data_bit_next    = pattern_word_reg[rd_pos[IDX_W-1:0]];
                pattern_pos_next = rd_pos + POS_W'(1);
                if (SIZE_W'(pattern_pos_next) >= size_eff)
                    pattern_pos_next = '0;
            end
            MODE_ONESHOT:
            begin
                if (SIZE_W'(pattern_pos_reg) < size_eff)
                begin
                    data_bit_next    = pattern_word_reg[pattern_pos_reg[IDX_W-1:0]];
                    pattern_pos_next = pattern_pos_reg + POS_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Count down a finite budget, or load it on a write of the limit register
    assign fin = !unlimited && (bits_left_reg == LIMIT_W'(1));

    always_comb
    begin
        bits_left_next = bits_left_reg;
        if (wr_limit)
            bits_left_next = wr_data[LIMIT_W-1:0];
        else if (gen && !unlimited)
            bits_left_next = bits_left_reg - LIMIT_W'(1);
    end

    // Load the result register, hold it while stalled
    assign out_valid_next = gen || (out_valid_reg && out_stall);
    assign final_bit_next = fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg       <= PRBS_SEED;
            pattern_pos_reg <= '0;
            bits_left_reg   <= LIMIT_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bits_left_reg <= bits_left_next;
            out_valid_reg <= out_valid_next;
            if (gen)
            begin
                shift_reg       <= shift_next;
                pattern_pos_reg <= pattern_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            data_bit_reg  <= data_bit_next;
            final_bit_reg <= final_bit_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_bit  = data_bit_reg;
    assign final_bit = final_bit_reg;

    // A bit that spends the last of the budget leaves it empty
    `PBS_ASSERT_NEXT(a_final_empties, gen && fin && !wr_limit, bits_left_reg == '0)
    // An unlimited budget stays unlimited until the limit is rewritten
    `PBS_ASSERT_NEXT(a_unlimited_holds, unlimited && !wr_limit, bits_left_reg[LIMIT_W-1])
    // An empty budget gives no result
    `PBS_ASSERT_NEXT(a_empty_no_result, in_acc && !unlimited && bits_left_reg == '0 && !out_stall, !out_valid_reg)
    // The pattern position never runs past the storage
    `PBS_ASSERT_NOW(a_pos_bound, 1'b1, SIZE_W'(pattern_pos_reg) <= SIZE_W'(PATTERN_BITS))

endmodule
